@@ design/ogpt_pkg.sv @@
// shared types and constants for the occupancy grid point thinner
package ogpt_pkg;

   localparam int COORD_W  = 16;
   localparam int SCALE_W  = 8;
   localparam int FRAC_W   = 15;
   localparam int PROD_W   = COORD_W + SCALE_W + 1;
   localparam int CELL_W   = 12;

   localparam logic signed [COORD_W-1:0] COORD_LIM = 16'sd16384;
   localparam logic [SCALE_W-1:0]        SCALE_RESET = 8'd10;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [SCALE_W-1:0]        scale_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [CELL_W-1:0]  cell_type;

endpackage

@@ design/ogpt_ram.sv @@
// generic simple dual port ram with registered read
module ogpt_ram #(
   parameter int WIDTH = 256,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/ogpt_cell.sv @@
// maps one q1.15 coordinate to a grid cell index over two register stages
module ogpt_cell
   import ogpt_pkg::*;
#(
   parameter int DISC_HALF = 5
) (
   input  logic      clock,
   input  logic      load,
   input  coord_type value,
   input  scale_type scale,
   output cell_type  cell_idx
);

   prod_type prod_ff;
   cell_type cell_ff;
   cell_type floor_w;
   cell_type offset_w;

   assign floor_w  = CELL_W'(signed'(prod_ff[PROD_W-1:FRAC_W]));
   assign offset_w = CELL_W'(DISC_HALF + 1) + cell_type'({1'b0, scale[SCALE_W-1:1]});

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= PROD_W'(value) * PROD_W'(signed'({1'b0, scale}));
      end
      cell_ff <= floor_w + offset_w;
   end

   assign cell_idx = cell_ff;

endmodule

@@ design/occupancy_grid_point_thinner_top.sv @@
// top level of the occupancy grid point thinner
//
// Points arrive on the req_ channel (x, y in signed q1.15, start_of_set) and
// each one gives exactly one rsp_keep result on the rsp_ channel, in order.
// A point outside (-0.5, 0.5) on either axis, or one whose grid cell is
// already marked, gets keep 0. A kept point marks a disc of DISC_SIZE rows
// around its cell in a GRID_SIDE x GRID_SIDE bitmap held as one row per ram
// word, with a valid bit per row so that start_of_set and reset clear it.
// A point passes through MAP, PROBE and TEST; a rejected point then goes to
// DONE, while a kept point first stamps its DISC_SIZE disc rows in STAMP,
// one row read-modify-write per cycle through the ram's read and write ports.
// The result sits in an output register, so a new point is taken while the
// receiver stalls; the block waits to hand over the next result until the
// register is free. csr_grid_scale is taken at any time, reset value 10, and
// must only change while no point is in flight.
// Reset is synchronous: all rows read as clear afterwards.
module occupancy_grid_point_thinner_top
   import ogpt_pkg::*;
#(
   parameter int GRID_SIDE = 256,
   parameter int DISC_SIZE = 11
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  coord_type req_point_x,
   input  coord_type req_point_y,
   input  logic      req_start_of_set,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output logic      rsp_keep,
   input  logic      csr_valid,
   output logic      csr_ready,
   input  scale_type csr_grid_scale
);

   localparam int DISC_HALF = DISC_SIZE / 2;
   localparam int ROW_W     = $clog2(GRID_SIDE);
   localparam int IDX_W     = $clog2(DISC_SIZE + 1);
   localparam int SEL_W     = $clog2(DISC_SIZE);
   localparam int WIDE_W    = GRID_SIDE + 2 * DISC_HALF;
   localparam int SH_W      = $clog2(WIDE_W);

   typedef logic [GRID_SIDE-1:0] row_type;
   typedef logic [WIDE_W-1:0]    wide_type;
   typedef logic [DISC_SIZE-1:0] disc_type;

   typedef enum logic [2:0] {IDLE, MAP, PROBE, TEST, STAMP, DONE} state_type;

   function automatic disc_type disc_bits(input int dy);
      disc_type m;
      int       dx;
      m = '0;
      for (int k = 0; k < DISC_SIZE; k++) begin
         dx   = k - DISC_HALF;
         m[k] = (4 * (dx * dx + dy * dy)) < (DISC_SIZE * DISC_SIZE);
      end
      return m;
   endfunction

   function automatic logic on_grid(input cell_type c);
      return (c >= cell_type'(0)) && (c < CELL_W'(GRID_SIDE));
   endfunction

   disc_type disc_rows [DISC_SIZE];

   for (genvar g = 0; g < DISC_SIZE; g++) begin : g_disc
      assign disc_rows[g] = disc_bits(g - DISC_HALF);
   end

   state_type           state_ff;
   scale_type           scale_ff;
   logic                rsp_valid_ff;
   logic                rsp_keep_ff;
   logic                keep_ff;
   logic                in_range_ff;
   logic                probe_on_ff;
   logic                probe_valid_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic [GRID_SIDE-1:0] row_valid_ff;
   logic                wr_pend_ff;
   logic [ROW_W-1:0]    wr_row_ff;
   logic                wr_valid_ff;
   row_type             wr_mask_ff;

   cell_type cx;
   cell_type cy;
   cell_type row_w;
   cell_type shamt_w;
   logic     col_ok_w;
   wide_type shifted_w;
   row_type  mask_w;
   logic     accept_w;
   logic     stamp_issue_w;
   logic     row_on_w;
   logic     hit_w;
   logic     ram_rd_en;
   logic [ROW_W-1:0] ram_rd_addr;
   row_type  ram_rd_data;
   row_type  ram_wr_data;
   logic     in_range_w;

   assign accept_w  = req_valid && req_ready;
   assign req_ready = (state_ff == IDLE);
   assign csr_ready = 1'b1;

   assign in_range_w = (req_point_x > -COORD_LIM) && (req_point_x < COORD_LIM) &&
                       (req_point_y > -COORD_LIM) && (req_point_y < COORD_LIM);

   ogpt_cell #(.DISC_HALF(DISC_HALF)) u_cell_x (
      .clock    (clock),
      .load     (accept_w),
      .value    (req_point_x),
      .scale    (scale_ff),
      .cell_idx (cx)
   );

   ogpt_cell #(.DISC_HALF(DISC_HALF)) u_cell_y (
      .clock    (clock),
      .load     (accept_w),
      .value    (req_point_y),
      .scale    (scale_ff),
      .cell_idx (cy)
   );

   // disc row placed at columns cx - half .. cx + half
   assign shamt_w   = cx + CELL_W'(DISC_HALF);
   assign col_ok_w  = (shamt_w >= cell_type'(0)) && (shamt_w < CELL_W'(WIDE_W));
   assign shifted_w = wide_type'(disc_rows[idx_ff[SEL_W-1:0]]) << shamt_w[SH_W-1:0];
   assign mask_w    = col_ok_w ? shifted_w[WIDE_W-1:2*DISC_HALF] : '0;

   assign row_w         = cy + cell_type'({1'b0, idx_ff}) - CELL_W'(DISC_HALF);
   assign row_on_w      = on_grid(row_w);
   assign stamp_issue_w = (state_ff == STAMP) && (idx_ff < IDX_W'(DISC_SIZE));

   assign ram_rd_en   = (state_ff == PROBE) || (stamp_issue_w && row_on_w);
   assign ram_rd_addr = (state_ff == PROBE) ? cy[ROW_W-1:0] : row_w[ROW_W-1:0];
   assign ram_wr_data = (wr_valid_ff ? ram_rd_data : '0) | wr_mask_ff;

   assign hit_w = probe_on_ff && probe_valid_ff && ram_rd_data[cx[ROW_W-1:0]];

   ogpt_ram #(.WIDTH(GRID_SIDE), .DEPTH(GRID_SIDE)) u_map (
      .clock   (clock),
      .wr_en   (wr_pend_ff),
      .wr_addr (wr_row_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_valid && csr_ready) begin
         scale_ff <= csr_grid_scale;
      end
   end

   // row valid bits: a cleared row reads as empty
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (accept_w && req_start_of_set) begin
         row_valid_ff <= '0;
      end else if (wr_pend_ff) begin
         row_valid_ff[wr_row_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_w) begin
         in_range_ff <= in_range_w;
      end
      if (state_ff == PROBE) begin
         probe_on_ff    <= on_grid(cx) && on_grid(cy);
         probe_valid_ff <= row_valid_ff[cy[ROW_W-1:0]];
      end
      wr_row_ff   <= row_w[ROW_W-1:0];
      wr_mask_ff  <= mask_w;
      wr_valid_ff <= row_valid_ff[row_w[ROW_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         rsp_keep_ff  <= 1'b0;
         keep_ff      <= 1'b0;
         idx_ff       <= '0;
         wr_pend_ff   <= 1'b0;
      end else begin
         wr_pend_ff <= stamp_issue_w && row_on_w;
         if (rsp_valid_ff && rsp_ready && (state_ff != DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (accept_w) begin
                  state_ff <= MAP;
               end
            end
            MAP: begin
               state_ff <= PROBE;
            end
            PROBE: begin
               state_ff <= TEST;
            end
            TEST: begin
               idx_ff <= '0;
               if (!in_range_ff || hit_w) begin
                  keep_ff  <= 1'b0;
                  state_ff <= DONE;
               end else begin
                  keep_ff  <= 1'b1;
                  state_ff <= STAMP;
               end
            end
            STAMP: begin
               if (idx_ff == IDX_W'(DISC_SIZE)) begin
                  state_ff <= DONE;
               end else begin
                  idx_ff <= idx_ff + IDX_W'(1);
               end
            end
            DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_keep_ff  <= keep_ff;
                  state_ff     <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_keep  = rsp_keep_ff;

   a_write_only_in_stamp: assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff |-> (state_ff == STAMP))
      else $error("bitmap written outside the stamp sequence");

   a_start_clears_rows: assert property (@(posedge clock) disable iff (reset)
      (accept_w && req_start_of_set) |=> (row_valid_ff == '0))
      else $error("start of set did not clear the bitmap");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == DONE))
      else $error("result raised outside the done state");

   a_stamp_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == STAMP) |-> (idx_ff <= IDX_W'(DISC_SIZE)))
      else $error("stamp row counter ran past the disc");

   a_keep_after_stamp: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == DONE) && keep_ff) |->
         (($past(state_ff) == STAMP) || ($past(state_ff) == DONE)))
      else $error("kept point reached done without a stamp");

endmodule

@@ verif/tb.sv @@
// testbench for the occupancy grid point thinner: directed table, random points, keep prediction
`timescale 1ns / 100ps

module tb
   import ogpt_pkg::*;
();

   localparam int GRID       = 256;
   localparam int DISC       = 11;
   localparam int TAIL       = 24;
   localparam int HOLD       = 300;
   localparam int STALL_MAX  = 2000;
   localparam int SEG_POINTS = 45;

   typedef struct packed {
      logic      set_scale;
      scale_type scale;
      int        x;
      int        y;
      logic      start;
      logic      known;
      logic      keep;
   } stim_row_type;

   logic      clock = 1'b0;
   logic      reset;
   logic      req_valid;
   logic      req_ready;
   coord_type req_point_x;
   coord_type req_point_y;
   logic      req_start_of_set;
   logic      rsp_valid;
   logic      rsp_ready;
   logic      rsp_keep;
   logic      csr_valid;
   logic      csr_ready;
   scale_type csr_grid_scale;

   bit        grid_marked [0:GRID-1][0:GRID-1];
   scale_type model_scale = SCALE_RESET;
   logic      pending_keep [$];
   int        fail_count = 0;
   int        tx_idle_pct = 0;
   int        rx_idle_pct = 0;
   bit        hold_request = 1'b0;
   int        hold_left = 0;
   int        quiet_cycles = 0;

   stim_row_type directed_rows [0:25] = '{
      '{1'b0, 8'd0,        0,      0, 1'b1, 1'b1, 1'b1},
      '{1'b0, 8'd0,        0,      0, 1'b0, 1'b1, 1'b0},
      '{1'b0, 8'd0,    16384,      0, 1'b0, 1'b1, 1'b0},
      '{1'b0, 8'd0,   -16384,      0, 1'b0, 1'b1, 1'b0},
      '{1'b0, 8'd0,        0,  16384, 1'b0, 1'b1, 1'b0},
      '{1'b0, 8'd0,        0, -16384, 1'b0, 1'b1, 1'b0},
      '{1'b0, 8'd0,    32767, -32768, 1'b0, 1'b1, 1'b0},
      '{1'b0, 8'd0,   -32768,  32767, 1'b0, 1'b1, 1'b0},
      '{1'b0, 8'd0,   -16385,      0, 1'b0, 1'b1, 1'b0},
      '{1'b0, 8'd0,    16383,  16383, 1'b0, 1'b0, 1'b0},
      '{1'b0, 8'd0,   -16383, -16383, 1'b0, 1'b0, 1'b0},
      '{1'b0, 8'd0,       -1,     -1, 1'b0, 1'b0, 1'b0},
      '{1'b0, 8'd0,     3277,  -3277, 1'b0, 1'b0, 1'b0},
      // clear on an out-of-range point
      '{1'b0, 8'd0,   -32768, -32768, 1'b1, 1'b1, 1'b0},
      '{1'b0, 8'd0,        0,      0, 1'b0, 1'b1, 1'b1},
      '{1'b0, 8'd0,   -16383,  16383, 1'b0, 1'b0, 1'b0},
      // scale 0 puts every point on the offset cell
      '{1'b1, 8'd0,     1000,  -1000, 1'b1, 1'b1, 1'b1},
      '{1'b0, 8'd0,    -5000,   7000, 1'b0, 1'b1, 1'b0},
      '{1'b1, 8'd1,        0,      0, 1'b1, 1'b1, 1'b1},
      '{1'b0, 8'd0,    16383, -16383, 1'b0, 1'b0, 1'b0},
      // scale 255 sends the far corner off the grid
      '{1'b1, 8'd255,  16383,  16383, 1'b1, 1'b0, 1'b0},
      '{1'b0, 8'd0,    16383,  16383, 1'b0, 1'b0, 1'b0},
      '{1'b0, 8'd0,   -16383, -16383, 1'b0, 1'b0, 1'b0},
      '{1'b1, 8'd244,      0,      0, 1'b1, 1'b1, 1'b1},
      '{1'b0, 8'd0,    16383,  16383, 1'b0, 1'b0, 1'b0},
      '{1'b1, 8'd10,       0,      0, 1'b1, 1'b1, 1'b1}
   };

   occupancy_grid_point_thinner_top #(
      .GRID_SIDE (GRID),
      .DISC_SIZE (DISC)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_start_of_set (req_start_of_set),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_keep         (rsp_keep),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_grid_scale   (csr_grid_scale)
   );

   always #5 clock = ~clock;

   function automatic bit on_grid(int c);
      return c >= 0 && c < GRID;
   endfunction

   function automatic int cell_of(coord_type v);
      int prod;
      prod = int'(v) * int'(model_scale);
      return (prod >>> FRAC_W) + DISC / 2 + 1 + int'(model_scale) / 2;
   endfunction

   function automatic logic thin_point(coord_type x, coord_type y, logic start);
      int lim;
      int cx;
      int cy;
      lim = int'(COORD_LIM);
      if (start) begin
         grid_marked = '{default: '{default: 1'b0}};
      end
      if (int'(x) <= -lim || int'(x) >= lim || int'(y) <= -lim || int'(y) >= lim) begin
         return 1'b0;
      end
      cx = cell_of(x);
      cy = cell_of(y);
      if (on_grid(cx) && on_grid(cy) && grid_marked[cy][cx]) begin
         return 1'b0;
      end
      for (int dy = -DISC / 2; dy <= DISC / 2; dy++) begin
         for (int dx = -DISC / 2; dx <= DISC / 2; dx++) begin
            if (on_grid(cy + dy) && on_grid(cx + dx) && 4 * (dx * dx + dy * dy) < DISC * DISC) begin
               grid_marked[cy + dy][cx + dx] = 1'b1;
            end
         end
      end
      return 1'b1;
   endfunction

   function automatic coord_type rand_coord();
      case ($urandom_range(9))
         0, 1: return coord_type'($urandom);
         2: return $urandom_range(1) ? coord_type'(16383 + $urandom_range(1))
                                     : coord_type'(-16383 - int'($urandom_range(1)));
         default: return coord_type'(int'($urandom_range(32766)) - 16383);
      endcase
   endfunction

   function automatic scale_type pick_scale();
      case ($urandom_range(7))
         0: return 8'd1;
         1: return 8'd244;
         2: return 8'd255;
         3: return 8'd0;
         default: return scale_type'($urandom_range(244, 60));
      endcase
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic push_point(coord_type x, coord_type y, logic start, logic known, logic keep);
      logic predicted;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_point_x      <= x;
      req_point_y      <= y;
      req_start_of_set <= start;
      do @(posedge clock); while (!req_ready);
      predicted = thin_point(x, y, start);
      pending_keep.push_back(known ? keep : predicted);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_keep.size() != 0) @(negedge clock);
      repeat (TAIL) @(negedge clock);
   endtask

   task automatic write_scale(scale_type value);
      csr_valid      <= 1'b1;
      csr_grid_scale <= value;
      do @(posedge clock); while (!csr_ready);
      model_scale = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_idle(int tx_pct, int rx_pct);
      @(posedge clock);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      @(negedge clock);
   endtask

   // receiver side
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      logic want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_keep.size() == 0) begin
            $error("keep transfer with nothing expected: got %0b", rsp_keep);
            fail_count++;
         end else begin
            want = pending_keep.pop_front();
            if (rsp_keep !== want) begin
               $error("keep mismatch: expected %0b, got %0b", want, rsp_keep);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_MAX) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_point_x      = '0;
      req_point_y      = '0;
      req_start_of_set = 1'b0;
      csr_valid        = 1'b0;
      csr_grid_scale   = SCALE_RESET;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].set_scale) begin
            drain_results();
            write_scale(directed_rows[i].scale);
         end
         push_point(coord_type'(directed_rows[i].x), coord_type'(directed_rows[i].y),
                    directed_rows[i].start, directed_rows[i].known, directed_rows[i].keep);
      end
      drain_results();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: set_idle(14, 62);
            1: set_idle(62, 14);
            default: set_idle(0, 0);
         endcase
         for (int seg = 0; seg < 3; seg++) begin
            drain_results();
            write_scale(pick_scale());
            // long receiver stall while points keep coming
            if (phase == 2 && seg == 1) begin
               @(posedge clock);
               hold_request = 1'b1;
               @(negedge clock);
            end
            for (int n = 0; n < SEG_POINTS; n++) begin
               if (phase == 2 && seg == 2 && n == 20) begin
                  drain_results();
               end
               push_point(rand_coord(), rand_coord(), $urandom_range(24) == 0, 1'b0, 1'b0);
            end
         end
      end
      drain_results();

      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/ogpt_pkg.sv
design/ogpt_ram.sv
design/ogpt_cell.sv
design/occupancy_grid_point_thinner_top.sv
verif/tb.sv
